// ===== rtl/core/svge_pkg.sv =====
// svge_pkg: types, codes and arithmetic helpers of the state vector gate engine.
// No dependencies; used by state_vector_gate_engine_top and its testbench.
package svge_pkg;

    localparam int MAX_QUBITS_DEF = 10;
    localparam int AMP_W          = 16;
    localparam int WORD_W         = 2 * AMP_W;
    localparam int ACC_W          = 36;
    localparam int CFG_W          = 4;
    localparam int CFG_IDX_W      = 1;
    localparam int DIV_STEPS      = 15;

    localparam logic signed [AMP_W-1:0] Q15_ONE = 16'sh7FFF;
    localparam logic signed [AMP_W-1:0] Q15_MAX = 16'sh7FFF;
    localparam logic signed [AMP_W-1:0] Q15_MIN = -16'sh8000;

    localparam logic [2:0] ACT_WRITE_AMP = 3'd0;
    localparam logic [2:0] ACT_READ_AMP  = 3'd1;
    localparam logic [2:0] ACT_WRITE_MAT = 3'd2;
    localparam logic [2:0] ACT_GATE1     = 3'd3;
    localparam logic [2:0] ACT_GATE2     = 3'd4;
    localparam logic [2:0] ACT_MEASURE   = 3'd5;
    localparam logic [2:0] ACT_RESET     = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_QUBITS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_QUBIT_MODE = 1'd1;

    typedef struct packed {
        logic [2:0]              action;
        logic [9:0]              amp_index;
        logic [3:0]              matrix_slot;
        logic signed [AMP_W-1:0] value_re;
        logic signed [AMP_W-1:0] value_im;
        logic [3:0]              target_bit;
        logic [3:0]              control_bit;
        logic [15:0]             random_fraction;
    } t_item;

    typedef struct packed {
        logic signed [AMP_W-1:0] read_re;
        logic signed [AMP_W-1:0] read_im;
        logic                    outcome;
        logic [15:0]             prob_zero;
        logic                    status;
    } t_res;

    // Q6.30 sum to Q1.15: add half, floor shift, saturate
    function automatic logic signed [AMP_W-1:0] round_q30(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] f;
        t = s + ACC_W'(16384);
        f = t >>> 15;
        if (f > ACC_W'(32767)) begin
            return Q15_MAX;
        end else if (f < -ACC_W'(32768)) begin
            return Q15_MIN;
        end
        return AMP_W'(f);
    endfunction

endpackage

// ===== rtl/core/svge_ram.sv =====
// svge_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module svge_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== rtl/core/state_vector_gate_engine_top.sv =====
// state_vector_gate_engine_top: fixed-point state vector engine around one amplitude RAM.
// Depends on svge_pkg and svge_ram.
// Gates work on groups of K amplitudes (K = 2 or 4) with a datapath of one MAC per
// cycle through the single RAM port pair; a measure item skips renormalization when
// the kept norm is zero. dim = 2^active_qubits, active_qubits clamped to 1..MAX_QUBITS.
// Reset: synchronous, active low; a clearing pass over all 2^MAX_QUBITS words follows
// during which no item is accepted.
module state_vector_gate_engine_top
    import svge_pkg::*;
#(
    parameter int MAX_QUBITS = MAX_QUBITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_item                i_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_res                 o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    localparam int ADDR_W = MAX_QUBITS;
    localparam int DEPTH  = 1 << MAX_QUBITS;
    localparam int IDX_W  = MAX_QUBITS + 1;
    localparam int QB_W   = $clog2(MAX_QUBITS + 1);
    localparam int SUM_W  = 32 + MAX_QUBITS;
    localparam int SQ_W   = 2 * ((SUM_W + 17) / 2);
    localparam int RT_W   = SQ_W / 2;
    localparam int NUM_W  = RT_W + 24;
    localparam int REM_W  = RT_W + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_GATE_SCAN, S_GATE_LOAD, S_GATE_MAC,
        S_MEAS_P0, S_MEAS_COL, S_SQRT, S_NORM_RD, S_NORM_LD, S_NORM_DIV,
        S_NORM_WR, S_FINISH
    } t_state;

    t_state               r_state;
    t_item                r_item;
    t_res                 r_res;
    t_res                 r_out;
    logic                 r_out_valid;
    logic [CFG_W-1:0]     r_active_qubits;
    logic                 r_two_qubit_mode;
    logic                 r_clr_item;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_gate2;
    logic                 r_quad;
    logic [ADDR_W-1:0]    r_grp [4];
    logic [WORD_W-1:0]    r_v [4];
    logic [WORD_W-1:0]    r_mat [16];
    logic [2:0]           r_ld;
    logic [1:0]           r_row;
    logic [1:0]           r_col;
    logic signed [ACC_W-1:0] r_acc_re;
    logic signed [ACC_W-1:0] r_acc_im;
    logic                 r_dv;
    logic [ADDR_W-1:0]    r_didx;
    logic [SUM_W-1:0]     r_p0;
    logic [SUM_W-1:0]     r_n2;
    logic                 r_outc;
    logic [SQ_W-1:0]      r_x;
    logic [SQ_W-1:0]      r_sres;
    logic [SQ_W-1:0]      r_bit;
    logic [RT_W-1:0]      r_s;
    logic [3:0]           r_cnt;
    logic [RT_W-1:0]      r_rem [2];
    logic [14:0]          r_q [2];
    logic [14:0]          r_nlo [2];
    logic                 r_neg [2];
    logic                 r_sat [2];

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [WORD_W-1:0]    mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [WORD_W-1:0]    mem_rdata;

    logic [QB_W-1:0]      eff_n;
    logic [IDX_W-1:0]     dim;
    logic [ADDR_W-1:0]    ia;
    logic [ADDR_W-1:0]    tm;
    logic [ADDR_W-1:0]    cm;
    logic                 in_bad_t;
    logic                 in_bad_c;
    logic                 in_bad;
    t_state               in_next;
    logic                 qual;
    logic [ADDR_W-1:0]    base;
    logic [2:0]           last_ld;
    logic [1:0]           last_col;
    logic [1:0]           ld_m1;
    logic [3:0]           midx;
    logic signed [AMP_W-1:0] m_re, m_im, v_re, v_im;
    logic signed [ACC_W-1:0] acc_re_n, acc_im_n;
    logic signed [AMP_W-1:0] d_re, d_im;
    logic [31:0]          sq;
    logic                 dbit;
    logic                 stream_done;
    logic                 outc_c;
    logic [SUM_W-1:0]     pq;
    logic [SQ_W-1:0]      sq_try;
    logic [NUM_W-1:0]     ld_num [2];
    logic                 ld_neg [2];
    logic                 ld_sat [2];
    logic [REM_W-1:0]     dv_rem2 [2];
    logic                 dv_ge [2];
    logic signed [AMP_W-1:0] wr_val [2];

    svge_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_amp_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        if (r_active_qubits == '0) begin
            eff_n = QB_W'(1);
        end else if (int'(r_active_qubits) > MAX_QUBITS) begin
            eff_n = QB_W'(MAX_QUBITS);
        end else begin
            eff_n = QB_W'(r_active_qubits);
        end
    end

    assign dim      = IDX_W'(1) << eff_n;
    assign ia       = r_idx[ADDR_W-1:0];
    assign tm       = ADDR_W'(1) << r_item.target_bit;
    assign cm       = ADDR_W'(1) << r_item.control_bit;
    assign in_bad_t = int'(i_item.target_bit) >= int'(eff_n);
    assign in_bad_c = (int'(i_item.control_bit) >= int'(eff_n))
                   || (i_item.control_bit == i_item.target_bit);

    always_comb begin
        in_bad  = 1'b0;
        in_next = S_FINISH;
        case (i_item.action)
            ACT_READ_AMP: in_next = S_READ;
            ACT_GATE1: begin
                in_bad = in_bad_t;
                if (!in_bad_t) in_next = S_GATE_SCAN;
            end
            ACT_GATE2: begin
                in_bad = in_bad_t || in_bad_c;
                if (!(in_bad_t || in_bad_c)) in_next = S_GATE_SCAN;
            end
            ACT_MEASURE: begin
                in_bad = in_bad_t;
                if (!in_bad_t) in_next = S_MEAS_P0;
            end
            ACT_RESET: in_next = S_CLEAR;
            default: ;
        endcase
    end

    assign qual     = r_gate2 ? ((|(ia & cm)) && !(|(ia & tm))) : !(|(ia & tm));
    assign base     = r_quad ? (ia & ~cm) : ia;
    assign last_ld  = r_quad ? 3'd4 : 3'd2;
    assign last_col = r_quad ? 2'd3 : 2'd1;
    assign ld_m1    = 2'(r_ld - 3'd1);
    assign midx     = r_quad ? {r_row, r_col} : {2'b00, r_row[0], r_col[0]};

    assign m_re = r_mat[midx][WORD_W-1:AMP_W];
    assign m_im = r_mat[midx][AMP_W-1:0];
    assign v_re = r_v[r_col][WORD_W-1:AMP_W];
    assign v_im = r_v[r_col][AMP_W-1:0];
    assign acc_re_n = r_acc_re + ACC_W'(m_re * v_re) - ACC_W'(m_im * v_im);
    assign acc_im_n = r_acc_im + ACC_W'(m_re * v_im) + ACC_W'(m_im * v_re);

    assign d_re        = mem_rdata[WORD_W-1:AMP_W];
    assign d_im        = mem_rdata[AMP_W-1:0];
    assign sq          = 32'(d_re * d_re) + 32'(d_im * d_im);
    assign dbit        = |(r_didx & tm);
    assign stream_done = (r_idx == dim) && !r_dv;
    assign outc_c      = SUM_W'({r_item.random_fraction, 14'h0}) > r_p0;
    assign pq          = (r_p0 + SUM_W'(8192)) >> 14;
    assign sq_try      = r_sres + r_bit;

    always_comb begin
        logic signed [AMP_W:0] xe;
        logic [AMP_W:0]        mag;
        for (int c = 0; c < 2; c++) begin
            xe        = (c == 0) ? (AMP_W+1)'(d_re) : (AMP_W+1)'(d_im);
            ld_neg[c] = xe[AMP_W];
            mag       = ld_neg[c] ? unsigned'(-xe) : unsigned'(xe);
            ld_num[c] = (NUM_W'(mag) << 23) + NUM_W'(r_s >> 1);
            ld_sat[c] = ld_num[c] >= (NUM_W'(r_s) << 15);
            dv_rem2[c] = {r_rem[c], r_nlo[c][14]};
            dv_ge[c]   = dv_rem2[c] >= REM_W'(r_s);
            if (r_sat[c]) begin
                wr_val[c] = r_neg[c] ? Q15_MIN : Q15_MAX;
            end else begin
                wr_val[c] = r_neg[c] ? -$signed({1'b0, r_q[c]}) : $signed({1'b0, r_q[c]});
            end
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = ia;
        mem_wdata = '0;
        mem_raddr = ia;
        unique case (r_state)
            S_IDLE: begin
                mem_raddr = ADDR_W'(i_item.amp_index);
                mem_waddr = ADDR_W'(i_item.amp_index);
                mem_wdata = {i_item.value_re, i_item.value_im};
                mem_we    = i_in_valid && (i_item.action == ACT_WRITE_AMP);
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = (r_idx == '0) ? {Q15_ONE, AMP_W'(0)} : '0;
            end
            S_GATE_LOAD: mem_raddr = r_grp[r_ld[1:0]];
            S_GATE_MAC: begin
                mem_waddr = r_grp[r_row];
                mem_wdata = {round_q30(acc_re_n), round_q30(acc_im_n)};
                mem_we    = (r_col == last_col);
            end
            S_MEAS_COL: begin
                mem_waddr = r_didx;
                mem_we    = r_dv && (dbit != r_outc);
            end
            S_NORM_WR: begin
                mem_wdata = {wr_val[0], wr_val[1]};
                mem_we    = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_CLEAR;
            r_idx            <= '0;
            r_clr_item       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_active_qubits  <= CFG_W'(10);
            r_two_qubit_mode <= 1'b0;
            r_dv             <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ACTIVE_QUBITS:  r_active_qubits  <= i_cfg_data;
                    CFG_TWO_QUBIT_MODE: r_two_qubit_mode <= i_cfg_data[0];
                endcase
            end
            if (r_out_valid && !i_out_stall && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_idx == IDX_W'(DEPTH - 1)) begin
                        r_state <= r_clr_item ? S_FINISH : S_IDLE;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item          <= i_item;
                        r_res.read_re   <= '0;
                        r_res.read_im   <= '0;
                        r_res.outcome   <= 1'b0;
                        r_res.prob_zero <= '0;
                        r_res.status    <= in_bad;
                        r_idx           <= '0;
                        r_dv            <= 1'b0;
                        r_clr_item      <= 1'b1;
                        r_state         <= in_next;
                        case (i_item.action)
                            ACT_WRITE_MAT: r_mat[i_item.matrix_slot] <=
                                               {i_item.value_re, i_item.value_im};
                            ACT_GATE1: begin
                                r_gate2 <= 1'b0;
                                r_quad  <= 1'b0;
                            end
                            ACT_GATE2: begin
                                r_gate2 <= 1'b1;
                                r_quad  <= !r_two_qubit_mode;
                            end
                            ACT_MEASURE: r_p0 <= '0;
                            default: ;
                        endcase
                    end
                end
                S_READ: begin
                    r_res.read_re <= d_re;
                    r_res.read_im <= d_im;
                    r_state       <= S_FINISH;
                end
                S_GATE_SCAN: begin
                    if (r_idx == dim) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        if (qual) begin
                            r_grp[0] <= base;
                            r_grp[1] <= base | tm;
                            r_grp[2] <= base | cm;
                            r_grp[3] <= base | cm | tm;
                            r_ld     <= '0;
                            r_state  <= S_GATE_LOAD;
                        end
                    end
                end
                S_GATE_LOAD: begin
                    if (r_ld != '0) r_v[ld_m1] <= mem_rdata;
                    if (r_ld == last_ld) begin
                        r_row    <= '0;
                        r_col    <= '0;
                        r_acc_re <= '0;
                        r_acc_im <= '0;
                        r_state  <= S_GATE_MAC;
                    end else begin
                        r_ld <= r_ld + 1'b1;
                    end
                end
                S_GATE_MAC: begin
                    if (r_col == last_col) begin
                        r_acc_re <= '0;
                        r_acc_im <= '0;
                        r_col    <= '0;
                        r_row    <= r_row + 1'b1;
                        if (r_row == last_col) r_state <= S_GATE_SCAN;
                    end else begin
                        r_acc_re <= acc_re_n;
                        r_acc_im <= acc_im_n;
                        r_col    <= r_col + 1'b1;
                    end
                end
                S_MEAS_P0, S_MEAS_COL: begin
                    if (r_idx != dim) begin
                        r_idx  <= r_idx + 1'b1;
                        r_dv   <= 1'b1;
                        r_didx <= ia;
                    end else begin
                        r_dv <= 1'b0;
                    end
                    if (r_state == S_MEAS_P0) begin
                        if (r_dv && !dbit) r_p0 <= r_p0 + SUM_W'(sq);
                        if (stream_done) begin
                            r_outc            <= outc_c;
                            r_res.outcome     <= outc_c;
                            r_res.prob_zero   <= (|pq[SUM_W-1:16]) ? 16'hFFFF : pq[15:0];
                            r_idx             <= '0;
                            r_n2              <= '0;
                            r_state           <= S_MEAS_COL;
                        end
                    end else begin
                        if (r_dv && (dbit == r_outc)) r_n2 <= r_n2 + SUM_W'(sq);
                        if (stream_done) begin
                            r_x     <= SQ_W'({r_n2, 16'h0});
                            r_sres  <= '0;
                            r_bit   <= SQ_W'(1) << (SQ_W - 2);
                            r_state <= (r_n2 == '0) ? S_FINISH : S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    if (r_bit == '0) begin
                        r_s     <= r_sres[RT_W-1:0];
                        r_idx   <= '0;
                        r_state <= S_NORM_RD;
                    end else begin
                        if (r_x >= sq_try) begin
                            r_x    <= r_x - sq_try;
                            r_sres <= (r_sres >> 1) + r_bit;
                        end else begin
                            r_sres <= r_sres >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_NORM_RD: r_state <= (r_idx == dim) ? S_FINISH : S_NORM_LD;
                S_NORM_LD: begin
                    for (int c = 0; c < 2; c++) begin
                        r_neg[c] <= ld_neg[c];
                        r_sat[c] <= ld_sat[c];
                        r_rem[c] <= RT_W'(ld_num[c] >> 15);
                        r_nlo[c] <= ld_num[c][14:0];
                        r_q[c]   <= '0;
                    end
                    r_cnt   <= '0;
                    r_state <= S_NORM_DIV;
                end
                S_NORM_DIV: begin
                    for (int c = 0; c < 2; c++) begin
                        r_rem[c] <= dv_ge[c] ? RT_W'(dv_rem2[c] - REM_W'(r_s))
                                             : RT_W'(dv_rem2[c]);
                        r_q[c]   <= {r_q[c][13:0], dv_ge[c]};
                        r_nlo[c] <= {r_nlo[c][13:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'(DIV_STEPS - 1)) r_state <= S_NORM_WR;
                end
                S_NORM_WR: begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_NORM_RD;
                end
                S_FINISH: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GATE_SCAN) |-> (r_idx <= dim))
        else $error("gate scan ran past the active region");

    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM_DIV) |-> (r_s != '0))
        else $error("normalization with zero root");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FINISH))
        else $error("result shown without finishing an item");

endmodule

// ===== test/tb_state_vector_gate_engine_top.sv =====
// Testbench for state_vector_gate_engine_top: drives random and directed items,
// predicts every result in a scoreboard class and checks it field by field.
// Depends on svge_pkg and the engine RTL.
`timescale 1ns / 100ps

module tb_state_vector_gate_engine_top;
    import svge_pkg::*;

    localparam logic [2:0] ACT_UNUSED = 3'd7;
    localparam int MAX_Q = 10;
    localparam int DEPTH = 1 << MAX_Q;
    localparam longint CYCLE_LIMIT = 4000000;

    class amp_scoreboard;
        int     amp_re[DEPTH];
        int     amp_im[DEPTH];
        int     mat_re[16];
        int     mat_im[16];
        int     qubits_reg;
        bit     mode_reg;
        t_res   pending_q[$];
        int     mismatches;

        function new();
            mismatches = 0;
            qubits_reg = 10;
            mode_reg = 0;
            for (int i = 0; i < 16; i++) begin
                mat_re[i] = 0;
                mat_im[i] = 0;
            end
            clear_state();
        endfunction

        function void clear_state();
            for (int i = 0; i < DEPTH; i++) begin
                amp_re[i] = 0;
                amp_im[i] = 0;
            end
            amp_re[0] = 32767;
        endfunction

        function void set_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_ACTIVE_QUBITS) qubits_reg = int'(data);
            else mode_reg = data[0];
        endfunction

        function int sat16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return int'(v);
        endfunction

        function int round30(longint s);
            longint f;
            f = (s + 16384) >>> 15;
            return sat16(f);
        endfunction

        function void apply_pair(int a, int b);
            longint r1, i1, r2, i2;
            int v1r, v1i, v2r, v2i;
            v1r = amp_re[a]; v1i = amp_im[a];
            v2r = amp_re[b]; v2i = amp_im[b];
            r1 = longint'(mat_re[0]) * v1r - longint'(mat_im[0]) * v1i
               + longint'(mat_re[1]) * v2r - longint'(mat_im[1]) * v2i;
            i1 = longint'(mat_re[0]) * v1i + longint'(mat_im[0]) * v1r
               + longint'(mat_re[1]) * v2i + longint'(mat_im[1]) * v2r;
            r2 = longint'(mat_re[2]) * v1r - longint'(mat_im[2]) * v1i
               + longint'(mat_re[3]) * v2r - longint'(mat_im[3]) * v2i;
            i2 = longint'(mat_re[2]) * v1i + longint'(mat_im[2]) * v1r
               + longint'(mat_re[3]) * v2i + longint'(mat_im[3]) * v2r;
            amp_re[a] = round30(r1); amp_im[a] = round30(i1);
            amp_re[b] = round30(r2); amp_im[b] = round30(i2);
        endfunction

        function void apply_quad(int base, int cm, int tm);
            int idx[4];
            int vr[4], vi[4];
            longint sr, si;
            int nr[4], ni[4];
            idx[0] = base; idx[1] = base | tm; idx[2] = base | cm; idx[3] = base | cm | tm;
            for (int r = 0; r < 4; r++) begin
                vr[r] = amp_re[idx[r]];
                vi[r] = amp_im[idx[r]];
            end
            for (int r = 0; r < 4; r++) begin
                sr = 0;
                si = 0;
                for (int c = 0; c < 4; c++) begin
                    sr += longint'(mat_re[r*4+c]) * vr[c] - longint'(mat_im[r*4+c]) * vi[c];
                    si += longint'(mat_re[r*4+c]) * vi[c] + longint'(mat_im[r*4+c]) * vr[c];
                end
                nr[r] = round30(sr);
                ni[r] = round30(si);
            end
            for (int r = 0; r < 4; r++) begin
                amp_re[idx[r]] = nr[r];
                amp_im[idx[r]] = ni[r];
            end
        endfunction

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function int renorm(int x, longint unsigned s);
            longint num;
            longint unsigned mag, q;
            longint v;
            num = longint'(x) * 8388608;
            mag = (num < 0) ? -num : num;
            q = (mag + s / 2) / s;
            v = (q > 65536) ? 65536 : longint'(q);
            return sat16(num < 0 ? -v : v);
        endfunction

        function longint unsigned mag2(int i);
            return longint'(amp_re[i]) * amp_re[i] + longint'(amp_im[i]) * amp_im[i];
        endfunction

        function void note(t_item it);
            t_res e;
            int n, dim, tm, cm;
            longint unsigned p0, n2, s, q;
            e = '0;
            n = (qubits_reg < 1) ? 1 : (qubits_reg > MAX_Q ? MAX_Q : qubits_reg);
            dim = 1 << n;
            tm = 1 << it.target_bit;
            cm = 1 << it.control_bit;
            case (it.action)
                ACT_WRITE_AMP: begin
                    amp_re[it.amp_index] = it.value_re;
                    amp_im[it.amp_index] = it.value_im;
                end
                ACT_READ_AMP: begin
                    e.read_re = 16'(amp_re[it.amp_index]);
                    e.read_im = 16'(amp_im[it.amp_index]);
                end
                ACT_WRITE_MAT: begin
                    mat_re[it.matrix_slot] = it.value_re;
                    mat_im[it.matrix_slot] = it.value_im;
                end
                ACT_GATE1: begin
                    if (it.target_bit >= n) e.status = 1'b1;
                    else for (int i = 0; i < dim; i++)
                        if ((i & tm) == 0) apply_pair(i, i | tm);
                end
                ACT_GATE2: begin
                    if (it.target_bit >= n || it.control_bit >= n
                        || it.target_bit == it.control_bit) begin
                        e.status = 1'b1;
                    end else begin
                        for (int i = 0; i < dim; i++) begin
                            if ((i & cm) != 0 && (i & tm) == 0) begin
                                if (mode_reg) apply_pair(i, i | tm);
                                else apply_quad(i & ~cm, cm, tm);
                            end
                        end
                    end
                end
                ACT_MEASURE: begin
                    if (it.target_bit >= n) begin
                        e.status = 1'b1;
                    end else begin
                        p0 = 0;
                        n2 = 0;
                        for (int i = 0; i < dim; i++)
                            if ((i & tm) == 0) p0 += mag2(i);
                        e.outcome = ((longint'(it.random_fraction) << 14) > p0);
                        q = (p0 + 8192) >> 14;
                        e.prob_zero = (q > 65535) ? 16'hFFFF : q[15:0];
                        for (int i = 0; i < dim; i++) begin
                            if (((i & tm) != 0) == e.outcome) begin
                                n2 += mag2(i);
                            end else begin
                                amp_re[i] = 0;
                                amp_im[i] = 0;
                            end
                        end
                        if (n2 != 0) begin
                            s = int_sqrt(n2 << 16);
                            for (int i = 0; i < dim; i++) begin
                                amp_re[i] = renorm(amp_re[i], s);
                                amp_im[i] = renorm(amp_im[i], s);
                            end
                        end
                    end
                end
                ACT_RESET: clear_state();
                default: ;
            endcase
            pending_q.push_back(e);
        endfunction

        function void check(t_res got);
            t_res e;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            e = pending_q.pop_front();
            if (got.read_re !== e.read_re || got.read_im !== e.read_im
                || got.outcome !== e.outcome || got.prob_zero !== e.prob_zero
                || got.status !== e.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: re %h/%h im %h/%h out %b/%b pz %h/%h st %b/%b (exp/got)",
                             e.read_re, got.read_re, e.read_im, got.read_im,
                             e.outcome, got.outcome, e.prob_zero, got.prob_zero,
                             e.status, got.status);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_item                i_item;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_res                 o_res;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    amp_scoreboard sb;
    bit            idle_on;
    bit            hold_req;
    int            hold_cnt;
    longint        cycles;
    int            cur_qubits;

    state_vector_gate_engine_top i_dut (.*);

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check(o_res);
        if (hold_req && hold_cnt == 0) begin
            hold_cnt <= 3000;
            i_out_stall <= 1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_stall <= (hold_cnt > 1);
        end else begin
            i_out_stall <= idle_on && ($urandom_range(99) < 8);
        end
    end

    task automatic send(t_item it);
        while (idle_on && $urandom_range(99) < 8) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note(it);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        drain();
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_cfg(idx, data);
        if (idx == CFG_ACTIVE_QUBITS)
            cur_qubits = (data < 1) ? 1 : (data > MAX_Q ? MAX_Q : int'(data));
    endtask

    function automatic t_item mk(logic [2:0] act, int idx, int slot, int re, int im,
                                 int tgt, int ctl);
        t_item it;
        it = '0;
        it.action = act;
        it.amp_index = 10'(idx);
        it.matrix_slot = 4'(slot);
        it.value_re = 16'(re);
        it.value_im = 16'(im);
        it.target_bit = 4'(tgt);
        it.control_bit = 4'(ctl);
        it.random_fraction = 16'($urandom);
        return it;
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int pick, dim;
        dim = 1 << cur_qubits;
        it = t_item'({$urandom, $urandom, 9'($urandom)});
        it.random_fraction = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 15) it.action = ACT_WRITE_AMP;
        else if (pick < 35) it.action = ACT_READ_AMP;
        else if (pick < 43) it.action = ACT_WRITE_MAT;
        else if (pick < 60) it.action = ACT_GATE1;
        else if (pick < 77) it.action = ACT_GATE2;
        else if (pick < 90) it.action = ACT_MEASURE;
        else if (pick < 96) it.action = ACT_RESET;
        else it.action = ACT_UNUSED;
        if ($urandom_range(3) != 0) it.amp_index = 10'($urandom_range(dim - 1));
        if ($urandom_range(9) != 0) begin
            it.target_bit = 4'($urandom_range(cur_qubits - 1));
            it.control_bit = 4'($urandom_range(cur_qubits - 1));
        end
        if ($urandom_range(2) == 0) begin
            it.value_re = $signed(16'($urandom_range(16383))) - 16'sd8192;
            it.value_im = $signed(16'($urandom_range(16383))) - 16'sd8192;
        end
        return it;
    endfunction

    initial begin
        int qlist[12];
        int cnt;
        qlist = '{1, 2, 3, 4, 0, 15, 3, 2, 4, 1, 3, 2};
        sb = new();
        cycles = 0;
        idle_on = 1;
        hold_req = 0;
        hold_cnt = 0;
        cur_qubits = 10;
        i_rst_n = 0;
        i_in_valid = 0;
        i_item = '0;
        i_out_stall = 0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: full matrix with extreme entries, then edge cases at 10 qubits
        for (int s = 0; s < 16; s++)
            send(mk(ACT_WRITE_MAT, 0, s,
                    (s == 0) ? 32767 : (s == 5) ? -32768 : (s % 5 == 0) ? 23170 : -1200 * s,
                    (s == 3) ? -32768 : (s == 10) ? 32767 : 700 * s, 0, 0));
        send(mk(ACT_READ_AMP, 0, 0, 0, 0, 0, 0));
        send(mk(ACT_WRITE_AMP, 1023, 15, -32768, 32767, 15, 15));
        send(mk(ACT_READ_AMP, 1023, 0, 0, 0, 0, 0));
        send(mk(ACT_GATE1, 0, 0, 0, 0, 10, 0));
        send(mk(ACT_GATE2, 0, 0, 0, 0, 4, 4));
        send(mk(ACT_GATE2, 0, 0, 0, 0, 9, 15));
        send(mk(ACT_GATE1, 0, 0, 0, 0, 9, 0));
        send(mk(ACT_MEASURE, 0, 0, 0, 0, 0, 0));
        send(mk(ACT_UNUSED, 1023, 15, -1, -1, 15, 15));
        send(mk(ACT_RESET, 0, 0, 0, 0, 0, 0));

        for (int ph = 0; ph < 12; ph++) begin
            write_cfg(CFG_ACTIVE_QUBITS, CFG_W'(qlist[ph]));
            write_cfg(CFG_TWO_QUBIT_MODE, CFG_W'(ph % 2));
            idle_on = (ph != 4);
            cnt = 22;
            for (int k = 0; k < cnt; k++) begin
                if (ph == 2 && k == 3) hold_req <= 1;
                if (ph == 2 && k == 4) hold_req <= 0;
                if (ph == 3 && k == 11) drain();
                send(rand_item());
            end
        end
        // a few items on the full store
        write_cfg(CFG_ACTIVE_QUBITS, CFG_W'(10));
        for (int k = 0; k < 8; k++) send(rand_item());

        drain();
        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/svge_pkg.sv
rtl/core/svge_ram.sv
rtl/core/state_vector_gate_engine_top.sv
test/tb_state_vector_gate_engine_top.sv
